### sv/fsa_pkg.sv
// shared constants, codes, command/status structs and register clamp
// for the fragmented sparse array; no dependencies
package fsa_pkg;

    localparam int MAX_FRAGS = 16;
    localparam int MAX_FLEN  = 16;
    localparam int VAL_W     = 32;

    localparam int FRAG_W  = $clog2(MAX_FRAGS);
    localparam int CELL_W  = $clog2(MAX_FLEN);
    localparam int ADDR_W  = FRAG_W + CELL_W;
    localparam int CELLS   = MAX_FRAGS * MAX_FLEN;
    localparam int CNT_W   = $clog2(MAX_FLEN + 1);
    localparam int TOT_W   = $clog2(CELLS + 1);
    localparam int ACT_W   = $clog2(MAX_FRAGS + 1);
    localparam int REG_W   = 5;
    localparam int IDX_W   = 16;
    localparam int KEY_W   = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_STEP_W = $clog2(ADDR_W);

    // input tdata: index, key; output tdata: status .. allocated_cells
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 64;

    localparam logic [CMD_W-1:0] CMD_SET      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_IS_SET   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOT_SET   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_LENGTH = 1'b1;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic lookup;
        logic scan_step;
        logic exec;
    } fsa_cmd_t;

    typedef struct packed {
        logic in_point;
        logic in_scan;
        logic div_done;
        logic scan_done;
        logic out_free;
    } fsa_stat_t;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v,
                                                   input logic [REG_W-1:0] maxv);
        logic [REG_W-1:0] r;
        if (v == '0) begin
            r = REG_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### sv/fsa_div.sv
// restoring divider, one quotient bit per cycle, splits an index into
// fragment and cell; depends on fsa_pkg
module fsa_div
    import fsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ADDR_W-1:0] dividend,
    input  logic [REG_W-1:0]  divisor,
    output logic              done,
    output logic [FRAG_W-1:0] quot,
    output logic [CELL_W-1:0] rem
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [REG_W-1:0]      rem_reg, rem_next;
    logic [ADDR_W-1:0]     quo_reg, quo_next;
    logic [REG_W-1:0]      dsr_reg, dsr_next;
    logic [REG_W:0]        trial;
    logic [REG_W:0]        diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[ADDR_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[REG_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
            end else begin
                rem_next = trial[REG_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
            end
            step_next = step_reg + DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(ADDR_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quo_reg[FRAG_W-1:0];
    assign rem  = rem_reg[CELL_W-1:0];

endmodule

### sv/fsa_dp.sv
// datapath: config registers, cell memory, valid bits, use counters,
// scan compare and output register; depends on fsa_pkg and fsa_div
module fsa_dp
    import fsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [REG_W-1:0]     cfg_wr_data,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_DATA_W-1:0]  m_tdata,
    input  fsa_cmd_t             ctl,
    output fsa_stat_t            stat
);

    logic [REG_W-1:0]  count_reg, len_reg;
    logic [REG_W-1:0]  nfrag, flen;
    logic [2*REG_W-1:0] capacity;

    logic [IDX_W-1:0]  in_index;
    logic [CMD_W-1:0]  in_cmd;
    logic              in_range_live;

    logic [CMD_W-1:0]  cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              in_range_reg;

    logic [CELLS-1:0]  valid_reg;
    logic [CNT_W-1:0]  use_cnt_reg [MAX_FRAGS];
    logic [TOT_W-1:0]  stored_reg, stored_next;
    logic [ACT_W-1:0]  active_reg, active_next;

    logic [VAL_W-1:0]  mem [CELLS];
    logic [VAL_W-1:0]  mem_q_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] rd_addr;

    logic              div_done;
    logic [FRAG_W-1:0] frag;
    logic [CELL_W-1:0] cell_idx;
    logic [ADDR_W-1:0] addr;

    logic [ADDR_W:0]   scan_addr_reg;
    logic [ADDR_W-1:0] cmp_addr_reg;
    logic              cmp_pend_reg;
    logic              scan_hit_reg;

    logic              cell_set;
    logic [CNT_W-1:0]  frag_cnt;
    logic [STAT_W-1:0] x_status;
    logic [VAL_W-1:0]  x_value;
    logic              x_hit, x_spawn, x_free;
    logic              x_mark, x_unmark, x_clear;
    logic [2*REG_W-1:0] alloc_prod;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              out_hit_reg, out_spawn_reg, out_free_reg;
    logic [TOT_W-1:0]  out_stored_reg;
    logic [ACT_W-1:0]  out_active_reg;
    logic [TOT_W-1:0]  out_alloc_reg;

    assign nfrag    = clamp_reg(count_reg, REG_W'(MAX_FRAGS));
    assign flen     = clamp_reg(len_reg, REG_W'(MAX_FLEN));
    assign capacity = nfrag * flen;

    assign in_index      = s_tdata[IDX_W-1:0];
    assign in_cmd        = s_tuser;
    assign in_range_live = !in_index[IDX_W-1]
                           && ({{(2*REG_W){1'b0}}, in_index} < {{IDX_W{1'b0}}, capacity});

    fsa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.div_start),
        .dividend (in_index[ADDR_W-1:0]),
        .divisor  (flen),
        .done     (div_done),
        .quot     (frag),
        .rem      (cell_idx)
    );

    assign addr = {frag, cell_idx};

    assign stat.in_point  = (in_cmd <= CMD_IS_SET) && in_range_live;
    assign stat.in_scan   = (in_cmd == CMD_CONTAINS);
    assign stat.div_done  = div_done;
    assign stat.scan_done = (scan_addr_reg == (ADDR_W+1)'(CELLS));
    assign stat.out_free  = !out_valid_reg || m_tready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= REG_W'(MAX_FRAGS);
            len_reg   <= REG_W'(MAX_FLEN);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_FRAG_COUNT:  count_reg <= cfg_wr_data;
                CFG_FRAG_LENGTH: len_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // transaction capture
    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            cmd_reg      <= in_cmd;
            key_reg      <= s_tdata[IDX_W +: KEY_W];
            in_range_reg <= in_range_live;
        end
    end

    // cell memory, registered read
    assign rd_addr = ctl.lookup ? addr : scan_addr_reg[ADDR_W-1:0];
    assign mem_re  = ctl.lookup || ctl.scan_step;
    assign mem_we  = ctl.exec && (cmd_reg == CMD_SET) && in_range_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr] <= key_reg[VAL_W-1:0];
        end
        if (mem_re) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // key search, compare runs in the cycle after the read
    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            scan_addr_reg <= '0;
            scan_hit_reg  <= 1'b0;
            cmp_pend_reg  <= 1'b0;
        end else begin
            cmp_pend_reg <= ctl.scan_step;
            if (ctl.scan_step) begin
                scan_addr_reg <= scan_addr_reg + (ADDR_W+1)'(1);
                cmp_addr_reg  <= scan_addr_reg[ADDR_W-1:0];
            end
            if (cmp_pend_reg && valid_reg[cmp_addr_reg]
                && (mem_q_reg == key_reg[VAL_W-1:0])) begin
                scan_hit_reg <= 1'b1;
            end
        end
    end

    // command execution
    assign cell_set = valid_reg[addr];
    assign frag_cnt = use_cnt_reg[frag];

    always_comb begin
        x_status = STATUS_OK;
        x_value  = '0;
        x_hit    = 1'b0;
        x_spawn  = 1'b0;
        x_free   = 1'b0;
        x_mark   = 1'b0;
        x_unmark = 1'b0;
        x_clear  = 1'b0;
        if ((cmd_reg <= CMD_IS_SET) && !in_range_reg) begin
            x_status = STATUS_BAD_INDEX;
        end else begin
            case (cmd_reg)
                CMD_SET: begin
                    if (!cell_set) begin
                        x_mark  = 1'b1;
                        x_spawn = (frag_cnt == '0);
                    end
                end
                CMD_GET: begin
                    if (cell_set) begin
                        x_value = mem_q_reg;
                        x_hit   = 1'b1;
                    end else begin
                        x_status = STATUS_NOT_SET;
                    end
                end
                CMD_DELETE: begin
                    if (cell_set) begin
                        x_unmark = 1'b1;
                        x_free   = (frag_cnt == CNT_W'(1));
                    end else begin
                        x_status = STATUS_NOT_SET;
                    end
                end
                CMD_IS_SET:   x_hit   = cell_set;
                CMD_CONTAINS: x_hit   = scan_hit_reg;
                CMD_CLEAR:    x_clear = 1'b1;
                default: ;
            endcase
        end

        if (x_clear) begin
            stored_next = '0;
            active_next = '0;
        end else if (x_mark) begin
            stored_next = stored_reg + TOT_W'(1);
            active_next = x_spawn ? active_reg + ACT_W'(1) : active_reg;
        end else if (x_unmark) begin
            stored_next = stored_reg - TOT_W'(1);
            active_next = x_free ? active_reg - ACT_W'(1) : active_reg;
        end else begin
            stored_next = stored_reg;
            active_next = active_reg;
        end
        alloc_prod = active_next * flen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (ctl.exec && x_clear)) begin
            valid_reg  <= '0;
            stored_reg <= '0;
            active_reg <= '0;
            for (int i = 0; i < MAX_FRAGS; i++) begin
                use_cnt_reg[i] <= '0;
            end
        end else if (ctl.exec) begin
            stored_reg <= stored_next;
            active_reg <= active_next;
            if (x_mark) begin
                valid_reg[addr]   <= 1'b1;
                use_cnt_reg[frag] <= frag_cnt + CNT_W'(1);
            end else if (x_unmark) begin
                valid_reg[addr]   <= 1'b0;
                use_cnt_reg[frag] <= frag_cnt - CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (ctl.exec) begin
            out_status_reg <= x_status;
            out_value_reg  <= x_value;
            out_hit_reg    <= x_hit;
            out_spawn_reg  <= x_spawn;
            out_free_reg   <= x_free;
            out_stored_reg <= stored_next;
            out_active_reg <= active_next;
            out_alloc_reg  <= alloc_prod[TOT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_alloc_reg, out_active_reg, out_stored_reg, out_free_reg,
                       out_spawn_reg, out_hit_reg, out_value_reg, out_status_reg};

endmodule

### sv/fsa_ctrl.sv
// controller state machine: sequences accept, divide, lookup, scan and
// execute steps for one transaction at a time; depends on fsa_pkg
module fsa_ctrl
    import fsa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  fsa_stat_t stat,
    output fsa_cmd_t  ctl
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_SCAN   = 5'b01000,
        S_EXEC   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.accept = 1'b1;
                    if (stat.in_point) begin
                        ctl.div_start = 1'b1;
                        state_next    = S_DIV;
                    end else if (stat.in_scan) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                ctl.lookup = 1'b1;
                state_next = S_EXEC;
            end
            S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = S_EXEC;
                end else begin
                    ctl.scan_step = 1'b1;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (stat.out_free) begin
                    ctl.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/fragmented_sparse_array_top.sv
// top level of the fragmented sparse array: controller plus datapath
// depends on fsa_pkg, fsa_ctrl, fsa_dp (which holds fsa_div)
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------
//  s_       | in        | s_tvalid/s_tready | tdata: index, key; tuser: cmd
//  m_       | out       | m_tvalid/m_tready | tdata: status .. allocated_cells
//  cfg_     | in        | cfg_wr_en         | cfg_wr_index, cfg_wr_data
//
// set, get, delete and is_set on a valid index go from accept through the bit-serial index divide
// and done flag, then memory read, then execute. contains_key reads all 256 cells through the one
// memory port before execute. clear_all, bad indices and unknown commands go from accept straight
// to execute.
// reset is synchronous and empties the array at once; the finished result waits
// in the output register and execution stalls only while that register is full.
module fragmented_sparse_array_top
    import fsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [REG_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // index[15:0], key[47:16]
    input  logic [CMD_W-1:0]     s_tuser,   // cmd[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata    // status[1:0], read_value[33:2], hit[34],
                                            // fragment_spawned[35], fragment_freed[36],
                                            // stored_count[45:37], active_fragments[50:46],
                                            // allocated_cells[59:51], zero[63:60]
);

    fsa_cmd_t  ctl;
    fsa_stat_t stat;

    fsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    fsa_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .ctl          (ctl),
        .stat         (stat)
    );

endmodule

### tb/sv/fragmented_sparse_array_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for fragmented_sparse_array_top: directed and random
// array commands checked against an in-bench shadow of the array; uses fsa_pkg
module fragmented_sparse_array_top_tb;
    import fsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SEGMENTS       = 9;
    localparam int SEGMENT_ITEMS  = 205;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [TOT_W-1:0]  alloc_cells;
        logic [ACT_W-1:0]  active_frags;
        logic [TOT_W-1:0]  stored;
        logic              freed;
        logic              spawned;
        logic              hit;
        logic [VAL_W-1:0]  read_value;
        logic [STAT_W-1:0] status;
    } array_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [REG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;   // index[15:0], key[47:16]
    logic [CMD_W-1:0]     s_tuser = '0;   // cmd[2:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;        // status, read_value, hit, fragment_spawned,
                                          // fragment_freed, stored_count, active_fragments,
                                          // allocated_cells, zero pad

    fragmented_sparse_array_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow copy of the array
    logic [REG_W-1:0] frag_count_reg = REG_W'(16);
    logic [REG_W-1:0] frag_len_reg = REG_W'(16);
    logic [VAL_W-1:0] cell_data [CELLS];
    bit               cell_used [CELLS];
    int               frag_fill [MAX_FRAGS];
    int               stored_total;
    int               active_total;

    array_result_t    expected_results [$];
    int               mismatch_count = 0;
    int               tx_idle_pct = 13;
    int               rx_idle_pct = 85;
    int               stall_cycles = 0;

    logic [VAL_W-1:0] key_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                       32'h7FFF_FFFF, 32'h0000_0001, 32'h1234_5678,
                                       32'hA5A5_A5A5, 32'h5A5A_5A5A};

    function automatic int effective_size(logic [REG_W-1:0] v, int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < CELLS; i++)
            cell_used[i] = 1'b0;
        for (int i = 0; i < MAX_FRAGS; i++)
            frag_fill[i] = 0;
        stored_total = 0;
        active_total = 0;
    endfunction

    function automatic array_result_t predict_array_op(logic [CMD_W-1:0] op,
                                                       logic [IDX_W-1:0] idx,
                                                       logic [KEY_W-1:0] key);
        array_result_t r;
        int nfrag, flen, frag, addr;
        bit in_range, found;
        r = '0;
        nfrag = effective_size(frag_count_reg, MAX_FRAGS);
        flen = effective_size(frag_len_reg, MAX_FLEN);
        in_range = !idx[IDX_W-1] && (int'(idx) < nfrag * flen);
        frag = 0;
        addr = 0;
        if (in_range) begin
            frag = int'(idx) / flen;
            addr = frag * MAX_FLEN + int'(idx) % flen;
        end
        if (op <= CMD_IS_SET && !in_range) begin
            r.status = STATUS_BAD_INDEX;
        end else begin
            case (op)
                CMD_SET: begin
                    if (!cell_used[addr]) begin
                        if (frag_fill[frag] == 0) begin
                            r.spawned = 1'b1;
                            active_total++;
                        end
                        frag_fill[frag]++;
                        stored_total++;
                        cell_used[addr] = 1'b1;
                    end
                    cell_data[addr] = key;
                end
                CMD_GET: begin
                    if (cell_used[addr]) begin
                        r.read_value = cell_data[addr];
                        r.hit = 1'b1;
                    end else begin
                        r.status = STATUS_NOT_SET;
                    end
                end
                CMD_DELETE: begin
                    if (cell_used[addr]) begin
                        cell_used[addr] = 1'b0;
                        stored_total--;
                        frag_fill[frag]--;
                        if (frag_fill[frag] == 0) begin
                            r.freed = 1'b1;
                            active_total--;
                        end
                    end else begin
                        r.status = STATUS_NOT_SET;
                    end
                end
                CMD_IS_SET: begin
                    r.hit = cell_used[addr];
                end
                CMD_CONTAINS: begin
                    found = 1'b0;
                    // only fragments in use are scanned
                    for (int f = 0; f < nfrag; f++) begin
                        if (frag_fill[f] != 0) begin
                            for (int c = 0; c < flen; c++) begin
                                if (cell_used[f * MAX_FLEN + c] &&
                                    cell_data[f * MAX_FLEN + c] == key)
                                    found = 1'b1;
                            end
                        end
                    end
                    r.hit = found;
                end
                CMD_CLEAR: begin
                    clear_shadow();
                end
                default: begin
                end
            endcase
        end
        r.stored = TOT_W'(stored_total);
        r.active_frags = ACT_W'(active_total);
        r.alloc_cells = TOT_W'(active_total * flen);
        return r;
    endfunction

    // entered and left just after a falling edge; tvalid stays high on return
    task automatic send_op(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic [KEY_W-1:0] key);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {key, idx};
        s_tuser <= op;
        do
            @(posedge aclk);
        while (!s_tready);
        expected_results.push_back(predict_array_op(op, idx, key));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [REG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= sel;
        cfg_wr_data <= val;
        if (sel == CFG_FRAG_COUNT)
            frag_count_reg = val;
        else
            frag_len_reg = val;
        clear_shadow();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_point_access();
        send_op(CMD_GET, 16'd0, 32'h0);
        send_op(CMD_DELETE, 16'd0, 32'h0);
        send_op(CMD_IS_SET, 16'd0, 32'h0);
        send_op(CMD_SET, 16'd0, 32'h7FFF_FFFF);
        send_op(CMD_SET, 16'd0, 32'h8000_0000);   // overwrite keeps counts
        send_op(CMD_SET, 16'd1, 32'h0);
        send_op(CMD_GET, 16'd0, 32'h0);
        send_op(CMD_IS_SET, 16'd1, 32'hFFFF_FFFF);
        send_op(CMD_SET, 16'd255, 32'hFFFF_FFFF);
        send_op(CMD_GET, 16'd255, 32'h0);
        send_op(CMD_DELETE, 16'd0, 32'h0);
        send_op(CMD_DELETE, 16'd1, 32'h0);
        send_op(CMD_DELETE, 16'd1, 32'h0);
    endtask

    task automatic test_index_bounds();
        send_op(CMD_SET, 16'd256, 32'h1);
        send_op(CMD_GET, 16'hFFFF, 32'h0);
        send_op(CMD_DELETE, 16'h8000, 32'h0);
        send_op(CMD_IS_SET, 16'h7FFF, 32'h0);
        send_op(CMD_SPARE_LO, 16'h7FFF, 32'hFFFF_FFFF);
        send_op(CMD_SPARE_HI, 16'hFFFF, 32'h0);
    endtask

    task automatic test_scan_and_clear();
        send_op(CMD_CONTAINS, 16'h0, 32'hFFFF_FFFF);
        send_op(CMD_CONTAINS, 16'hFFFF, 32'h1234_5678);
        send_op(CMD_CLEAR, 16'h0, 32'h0);
        send_op(CMD_GET, 16'd255, 32'h0);
    endtask

    task automatic send_random_op();
        int cap, sel;
        logic [CMD_W-1:0] op;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        cap = effective_size(frag_count_reg, MAX_FRAGS) *
              effective_size(frag_len_reg, MAX_FLEN);
        sel = $urandom_range(0, 99);
        if (sel < 30)
            op = CMD_SET;
        else if (sel < 50)
            op = CMD_GET;
        else if (sel < 68)
            op = CMD_DELETE;
        else if (sel < 80)
            op = CMD_IS_SET;
        else if (sel < 85)
            op = CMD_CONTAINS;
        else if (sel < 87)
            op = CMD_CLEAR;
        else if (sel < 89)
            op = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        else
            op = CMD_SET;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            idx = IDX_W'($urandom_range(0, 65535));
        else if (sel < 14)
            idx = IDX_W'(cap + $urandom_range(0, 3));
        else if (sel < 55)
            idx = IDX_W'($urandom_range(0, cap - 1));
        else
            // a few hot cells so fragments fill up and empty again
            idx = IDX_W'($urandom_range(0, (cap < 12 ? cap : 12) - 1));
        if ($urandom_range(0, 99) < 70)
            key = key_pool[$urandom_range(0, 7)];
        else
            key = $urandom();
        send_op(op, idx, key);
    endtask

    task automatic test_random_mix();
        logic [REG_W-1:0] seg_count [SEGMENTS] = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd3, 5'd5,
                                                   5'd16, 5'd2, 5'd9};
        logic [REG_W-1:0] seg_len [SEGMENTS] = '{5'd31, 5'd1, 5'd0, 5'd1, 5'd31, 5'd7,
                                                 5'd16, 5'd16, 5'd4};
        for (int s = 0; s < SEGMENTS; s++) begin
            drain();
            if (s < 3) begin
                tx_idle_pct = 13;
                rx_idle_pct = 85;
            end else if (s < 6) begin
                tx_idle_pct = 85;
                rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (s == SEGMENTS - 1) begin
                write_reg(CFG_FRAG_COUNT, REG_W'($urandom_range(0, 31)));
                write_reg(CFG_FRAG_LENGTH, REG_W'($urandom_range(0, 31)));
            end else begin
                write_reg(CFG_FRAG_COUNT, seg_count[s]);
                write_reg(CFG_FRAG_LENGTH, seg_len[s]);
            end
            for (int i = 0; i < SEGMENT_ITEMS; i++)
                send_random_op();
        end
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        array_result_t want;
        array_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = array_result_t'(m_tdata[$bits(array_result_t)-1:0]);
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: 0x%0h", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("read_value", want.read_value, got.read_value);
                check_field("hit", 32'(want.hit), 32'(got.hit));
                check_field("fragment_spawned", 32'(want.spawned), 32'(got.spawned));
                check_field("fragment_freed", 32'(want.freed), 32'(got.freed));
                check_field("stored_count", 32'(want.stored), 32'(got.stored));
                check_field("active_fragments", 32'(want.active_frags),
                            32'(got.active_frags));
                check_field("allocated_cells", 32'(want.alloc_cells), 32'(got.alloc_cells));
            end
        end
    end

    // counts cycles in which no transaction or register write happens
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("fragmented_sparse_array_top: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        clear_shadow();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_point_access();
        test_index_bounds();
        test_scan_and_clear();
        test_random_mix();
        drain();
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("fragmented_sparse_array_top: match");
        else
            $display("fragmented_sparse_array_top: mismatch");
        $finish;
    end

endmodule
